// ===== sv/crchs_pkg.sv =====
// crchs_pkg: shared types, codes and the crc byte step for the hashed key set
// used by crchs_hash and crc_hashed_open_address_key_set; no dependencies
`default_nettype none

package crchs_pkg;

    // field widths fixed by the interface
    localparam int KEY_W    = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 11;
    localparam int MARK_W   = 2;

    localparam logic [CNT_W-1:0] FILL_LIMIT_RESET = 11'd512;

    // crc constants
    localparam logic [KEY_W-1:0] CRC_POLY = 32'h1EDC6F41;
    localparam logic [KEY_W-1:0] CRC_INIT = 32'hFFFFFFFF;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    // slot marks
    localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
    localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
    localparam logic [MARK_W-1:0] MARK_GONE  = 2'd2;

    // hash unit states
    typedef enum logic [1:0] {
        H_IDLE,
        H_CRC,
        H_MOD
    } t_hash_state;

    // main sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_FINISH
    } t_state;

    // one byte of the reflected crc update, eight bit steps
    function automatic logic [KEY_W-1:0] crc_byte(input logic [KEY_W-1:0] c_in,
                                                   input logic [7:0]       b);
        logic [KEY_W-1:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/crchs_hash.sv =====
// crchs_hash: home slot unit, crc over the four key bytes then modulo table size
// depends on crchs_pkg; a size that is not a power of two uses a reciprocal multiply
`default_nettype none

module crchs_hash #(
    parameter int  TABLE_SIZE = 1024,
    localparam int IdxW       = $clog2(TABLE_SIZE)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [crchs_pkg::KEY_W-1:0] i_key,
    output logic                           o_done,
    output logic [IdxW-1:0]                o_home
);
    import crchs_pkg::*;

    localparam bit             IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
    localparam logic [IdxW:0]  SIZE_W  = (IdxW + 1)'(TABLE_SIZE);
    // floor(2^32 / size): the quotient estimate is exact or one short
    localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << KEY_W) / TABLE_SIZE);

    t_hash_state        r_state, n_state;
    logic [1:0]         r_cnt;
    logic               r_done;
    logic [KEY_W-1:0]   r_key;
    logic [KEY_W-1:0]   r_crc;
    logic [2*KEY_W-1:0] r_prod;
    logic [IdxW:0]      r_diff;
    logic [IdxW-1:0]    r_home;

    logic               crc_step, mod_step, last_byte, last_mod;
    logic [KEY_W-1:0]   n_crc, crc_final;
    logic [2*KEY_W-1:0] n_prod;
    logic [IdxW:0]      n_diff;
    logic [IdxW-1:0]    n_home;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            H_IDLE: if (i_start) n_state = H_CRC;
            H_CRC: begin
                if (last_byte) n_state = IS_POW2 ? H_IDLE : H_MOD;
            end
            H_MOD: if (last_mod) n_state = H_IDLE;
            default: n_state = H_IDLE;
        endcase
    end

    // step controls
    always_comb begin
        crc_step  = (r_state == H_CRC);
        mod_step  = (r_state == H_MOD);
        last_byte = (r_cnt == 2'd3);
        last_mod  = (r_cnt == 2'd2);
    end

    // datapath: one key byte per cycle, then product, remainder estimate and correction
    always_comb begin
        n_crc     = crc_byte(r_crc, r_key[{r_cnt, 3'b000} +: 8]);
        crc_final = ~n_crc;
        n_prod    = (2*KEY_W)'(r_crc) * (2*KEY_W)'(RECIP);
        n_diff    = r_crc[IdxW:0] - r_prod[KEY_W +: IdxW+1] * SIZE_W;
        n_home    = (r_diff >= SIZE_W) ? IdxW'(r_diff - SIZE_W) : IdxW'(r_diff);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            if (r_state == H_IDLE) begin
                r_cnt <= '0;
            end else if (crc_step && last_byte) begin
                r_cnt  <= '0;
                r_done <= IS_POW2;
            end else begin
                r_cnt  <= r_cnt + 2'd1;
                r_done <= mod_step && last_mod;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == H_IDLE && i_start) begin
            r_key <= i_key;
            r_crc <= CRC_INIT;
        end else if (crc_step) begin
            if (last_byte) begin
                r_crc <= crc_final;
                if (IS_POW2) r_home <= crc_final[IdxW-1:0];
            end else begin
                r_crc <= n_crc;
            end
        end else if (mod_step) begin
            unique case (r_cnt)
                2'd0:    r_prod <= n_prod;
                2'd1:    r_diff <= n_diff;
                default: r_home <= n_home;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_home = r_home;

endmodule

`default_nettype wire

// ===== sv/crc_hashed_open_address_key_set.sv =====
// crc_hashed_open_address_key_set: open addressing key set over one slot memory
// depends on crchs_pkg and crchs_hash
`default_nettype none

// Set of 32-bit keys: insert, search or delete, one transaction at a time.
// After reset the block runs a clearing pass over the slot memory with busy
// high. A transaction is taken when start is high and busy is low; its result
// appears on the o_ ports for one cycle with o_valid high, and busy falls in
// that same cycle. The delay from acceptance to the result strobe is set by
// four crc byte steps and one slot memory read per probe with the reads
// pipelined one per cycle, plus the reciprocal modulo steps when TABLE_SIZE
// is not a power of two. The receiver cannot stall: results must be taken in
// their strobe cycle. The user must write fill_limit with i_cfg_we only while
// idle; the block itself does not enforce this.

module crc_hashed_open_address_key_set #(
    parameter int TABLE_SIZE = 1024,
    parameter int MAX_PROBES = 11
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [crchs_pkg::CNT_W-1:0]    i_cfg_data,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [crchs_pkg::MODE_W-1:0]   i_mode,
    input  wire logic [crchs_pkg::KEY_W-1:0]    i_key,
    output logic                              o_valid,
    output logic                              o_found,
    output logic [crchs_pkg::STATUS_W-1:0]      o_status,
    output logic [crchs_pkg::CNT_W-1:0]         o_key_count
);
    import crchs_pkg::*;

    localparam int             IdxW   = $clog2(TABLE_SIZE);
    localparam int             PidxW  = $clog2(MAX_PROBES + 1);
    localparam int             WordW  = MARK_W + KEY_W;
    localparam logic [IdxW:0]  SIZE_W = (IdxW + 1)'(TABLE_SIZE);
    localparam logic [IdxW-1:0] LAST_SLOT = IdxW'(TABLE_SIZE - 1);
    localparam logic [PidxW-1:0] PROBE_END = PidxW'(MAX_PROBES);

    // slot memory: mark over key
    logic [WordW-1:0]   mem [TABLE_SIZE];
    logic [WordW-1:0]   r_rdata;

    t_state             r_state, n_state;
    logic [IdxW-1:0]    r_clr_addr;
    logic [CNT_W-1:0]   r_fill_limit;
    logic [CNT_W-1:0]   r_count;
    logic [PidxW-1:0]   r_pidx;
    logic               r_rd_valid;
    logic               r_found;
    logic               r_free_ok;
    logic               r_out_valid;

    logic [MODE_W-1:0]  r_mode;
    logic [KEY_W-1:0]   r_key;
    logic [IdxW-1:0]    r_off;
    logic [IdxW-1:0]    r_rd_slot;
    logic [IdxW-1:0]    r_at;
    logic [IdxW-1:0]    r_free_slot;
    logic               r_out_found;
    logic [STATUS_W-1:0] r_out_status;

    logic               hash_done;
    logic [IdxW-1:0]    hash_home;

    logic               accept;
    logic [IdxW:0]      probe_sum, off_dbl;
    logic [IdxW-1:0]    probe_slot, off_next;
    logic [MARK_W-1:0]  rd_mark;
    logic [KEY_W-1:0]   rd_key;
    logic               eval, hit_empty, hit_match, stop, last, issue;
    logic               do_write, mem_we;
    logic [IdxW-1:0]    fin_addr, mem_waddr;
    logic [MARK_W-1:0]  fin_mark;
    logic [WordW-1:0]   mem_wdata;
    logic [STATUS_W-1:0] n_status;
    logic [CNT_W-1:0]   n_count;

    // home slot unit
    crchs_hash #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_hash (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(accept),
        .i_key  (i_key),
        .o_done (hash_done),
        .o_home (hash_home)
    );

    // probe address: home plus offset, offsets double modulo the table size
    always_comb begin
        probe_sum  = {1'b0, hash_home} + {1'b0, r_off};
        probe_slot = (probe_sum >= SIZE_W) ? IdxW'(probe_sum - SIZE_W) : IdxW'(probe_sum);
        off_dbl    = {r_off, 1'b0};
        if (r_pidx == '0) begin
            off_next = IdxW'(1);
        end else begin
            off_next = (off_dbl >= SIZE_W) ? IdxW'(off_dbl - SIZE_W) : IdxW'(off_dbl);
        end
    end

    // probe evaluation of the slot read in the previous cycle
    always_comb begin
        rd_mark   = r_rdata[WordW-1:KEY_W];
        rd_key    = r_rdata[KEY_W-1:0];
        eval      = (r_state == S_PROBE) && r_rd_valid;
        hit_empty = eval && (rd_mark == MARK_EMPTY);
        hit_match = eval && (rd_mark == MARK_USED) && (rd_key == r_key);
        stop      = hit_empty || hit_match;
        last      = (r_pidx == PROBE_END);
        issue     = (r_state == S_PROBE) && !stop && !last;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr_addr == LAST_SLOT) n_state = S_IDLE;
            S_IDLE:   if (accept) n_state = S_HASH;
            S_HASH:   if (hash_done) n_state = S_PROBE;
            S_PROBE:  if (stop || last) n_state = S_FINISH;
            S_FINISH: n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    // outputs of the sequencer and the final decision of a transaction
    always_comb begin
        busy     = !i_rst_n || (r_state != S_IDLE);
        accept   = start && !busy;
        n_status = ST_DONE;
        n_count  = r_count;
        do_write = 1'b0;
        fin_addr = r_free_slot;
        fin_mark = MARK_USED;
        unique case (r_mode)
            MODE_INSERT: begin
                if (r_found) begin
                    n_status = ST_DUP;
                end else if (({1'b0, r_count} + 12'd1) > {1'b0, r_fill_limit}) begin
                    n_status = ST_FULL;
                end else if (r_free_ok) begin
                    do_write = 1'b1;
                    n_count  = r_count + 11'd1;
                end else begin
                    n_status = ST_FULL;
                end
            end
            MODE_DELETE: begin
                if (r_found) begin
                    do_write = 1'b1;
                    fin_addr = r_at;
                    fin_mark = MARK_GONE;
                    if (r_count != '0) n_count = r_count - 11'd1;
                end else begin
                    n_status = ST_ABSENT;
                end
            end
            default: n_status = ST_DONE;
        endcase
        mem_we    = (r_state == S_CLEAR) || ((r_state == S_FINISH) && do_write);
        mem_waddr = (r_state == S_CLEAR) ? r_clr_addr : fin_addr;
        mem_wdata = (r_state == S_CLEAR) ? {MARK_EMPTY, {KEY_W{1'b0}}} : {fin_mark, r_key};
    end

    // slot memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (issue)  r_rdata <= mem[probe_slot];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_fill_limit <= FILL_LIMIT_RESET;
            r_count      <= '0;
            r_pidx       <= '0;
            r_rd_valid   <= 1'b0;
            r_found      <= 1'b0;
            r_free_ok    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_valid  <= issue;
            r_out_valid <= (r_state == S_FINISH);
            if (i_cfg_we) r_fill_limit <= i_cfg_data;
            if (r_state == S_CLEAR) r_clr_addr <= r_clr_addr + IdxW'(1);
            // start of the probe sequence
            if (r_state == S_HASH) begin
                r_pidx    <= '0;
                r_found   <= 1'b0;
                r_free_ok <= 1'b0;
            end
            if (issue) r_pidx <= r_pidx + PidxW'(1);
            if (hit_match) r_found <= 1'b1;
            if (eval && (rd_mark != MARK_USED)) r_free_ok <= 1'b1;
            if (r_state == S_FINISH) r_count <= n_count;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_mode;
            r_key  <= i_key;
        end
        if (r_state == S_HASH) r_off <= '0;
        if (issue) begin
            r_off     <= off_next;
            r_rd_slot <= probe_slot;
        end
        if (hit_match) r_at <= r_rd_slot;
        if (eval && (rd_mark != MARK_USED) && !r_free_ok) r_free_slot <= r_rd_slot;
        if (r_state == S_FINISH) begin
            r_out_found  <= r_found;
            r_out_status <= n_status;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_found     = r_out_found;
    assign o_status    = r_out_status;
    assign o_key_count = r_count;

    // an accepted transaction keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after an accepted transaction");

    // result strobe lasts one cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    // a result only follows the finishing step
    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == S_FINISH))
        else $error("result strobe without a finishing step");

    // a refused or failed transaction never touches the slot memory
    a_no_write_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FINISH) && (n_status != ST_DONE)) |-> !mem_we)
        else $error("slot memory written by a refused transaction");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking bench for crc_hashed_open_address_key_set
// drives insert, search and delete transactions and checks each result strobe
// against an in-bench model of the key set; depends on crchs_pkg and the block
module tb_top;

    import crchs_pkg::*;

    localparam int TABLE_SIZE   = 1024;
    localparam int MAX_PROBES   = 11;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int TAIL_CYCLES  = 40;
    localparam int POOL_SIZE    = 36;
    localparam int PHASE_ITEMS  = 125;
    localparam int PHASE_COUNT  = 6;

    // the unused mode code behaves as a search
    localparam logic [MODE_W-1:0] MODE_ALIAS_SEARCH = 2'd3;

    typedef struct packed {
        logic                found;
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    count;
    } t_key_op_result;

    // dut signals, every input known from time zero
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [CNT_W-1:0]    i_cfg_data  = '0;
    logic                start       = 1'b0;
    logic [MODE_W-1:0]   i_mode      = MODE_SEARCH;
    logic [KEY_W-1:0]    i_key       = '0;
    logic                busy;
    logic                o_valid;
    logic                o_found;
    logic [STATUS_W-1:0] o_status;
    logic [CNT_W-1:0]    o_key_count;

    // model of the key set
    logic [KEY_W-1:0]  model_keys  [TABLE_SIZE];
    logic [MARK_W-1:0] model_marks [TABLE_SIZE];
    logic [CNT_W-1:0]  model_count      = '0;
    logic [CNT_W-1:0]  model_fill_limit = FILL_LIMIT_RESET;

    t_key_op_result pending_results [$];
    int             error_count = 0;
    int             cycle_count = 0;

    crc_hashed_open_address_key_set #(
        .TABLE_SIZE (TABLE_SIZE),
        .MAX_PROBES (MAX_PROBES)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .start       (start),
        .busy        (busy),
        .i_mode      (i_mode),
        .i_key       (i_key),
        .o_valid     (o_valid),
        .o_found     (o_found),
        .o_status    (o_status),
        .o_key_count (o_key_count)
    );

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // reflected crc over the whole word: xor in all four bytes, then 32 bit steps
    function automatic logic [KEY_W-1:0] crc32c_word(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] c;
        c = CRC_INIT ^ k;
        for (int i = 0; i < 32; i++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
        end
        return ~c;
    endfunction

    function automatic int unsigned home_slot(input logic [KEY_W-1:0] k);
        return crc32c_word(k) % TABLE_SIZE;
    endfunction

    // offsets 0, 1, 2, 4, ... from the home slot
    function automatic int unsigned probe_at(input int unsigned home, input int p);
        int unsigned off;
        off = (p == 0) ? 0 : (1 << (p - 1));
        return (home + off) % TABLE_SIZE;
    endfunction

    // apply one transaction to the model and return the result it should give
    function automatic t_key_op_result apply_key_op(input logic [MODE_W-1:0] op,
                                                    input logic [KEY_W-1:0]  k);
        t_key_op_result r;
        int unsigned    home;
        int unsigned    s;
        int             hit_slot;
        bit             stop;
        bit             placed;
        home     = home_slot(k);
        hit_slot = -1;
        stop     = 1'b0;
        placed   = 1'b0;
        // lookup stops at an empty slot and skips deleted ones
        for (int p = 0; p < MAX_PROBES && !stop; p++) begin
            s = probe_at(home, p);
            if (model_marks[s] == MARK_EMPTY) begin
                stop = 1'b1;
            end else if (model_marks[s] == MARK_USED && model_keys[s] == k) begin
                hit_slot = s;
                stop     = 1'b1;
            end
        end
        r.found  = (hit_slot >= 0);
        r.status = ST_DONE;
        case (op)
            MODE_INSERT: begin
                if (r.found) begin
                    r.status = ST_DUP;
                end else if (int'(model_count) + 1 > int'(model_fill_limit)) begin
                    r.status = ST_FULL;
                end else begin
                    // first empty or deleted slot in probe order
                    r.status = ST_FULL;
                    for (int p = 0; p < MAX_PROBES && !placed; p++) begin
                        s = probe_at(home, p);
                        if (model_marks[s] != MARK_USED) begin
                            model_marks[s] = MARK_USED;
                            model_keys[s]  = k;
                            model_count    = model_count + 1'b1;
                            r.status       = ST_DONE;
                            placed         = 1'b1;
                        end
                    end
                end
            end
            MODE_DELETE: begin
                if (r.found) begin
                    model_marks[hit_slot] = MARK_GONE;
                    if (model_count > 0) begin
                        model_count = model_count - 1'b1;
                    end
                end else begin
                    r.status = ST_ABSENT;
                end
            end
            default: begin
            end
        endcase
        r.count = model_count;
        return r;
    endfunction

    // random key whose home slot is h
    function automatic logic [KEY_W-1:0] key_with_home(input int unsigned h);
        logic [KEY_W-1:0] k;
        k = $urandom;
        while (home_slot(k) != h) begin
            k = $urandom;
        end
        return k;
    endfunction

    // one transaction: hold start until the block takes it
    task automatic send_key_op(input logic [MODE_W-1:0] op, input logic [KEY_W-1:0] k);
        start  <= 1'b1;
        i_mode <= op;
        i_key  <= k;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(apply_key_op(op, k));
    endtask

    // sender gap, mostly short with the odd long one
    task automatic pause_sender(input bit allow);
        int n;
        int pick;
        n    = 0;
        pick = $urandom_range(0, 99);
        if (allow) begin
            if (pick < 45) n = 0;
            else if (pick < 88) n = $urandom_range(1, 4);
            else if (pick < 96) n = $urandom_range(5, 18);
            else n = $urandom_range(19, 40);
        end
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // wait until every result is in and the block is idle
    task automatic wait_for_idle();
        start <= 1'b0;
        while (pending_results.size() != 0 || busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic write_fill_limit(input logic [CNT_W-1:0] value);
        wait_for_idle();
        i_cfg_we         <= 1'b1;
        i_cfg_data       <= value;
        model_fill_limit  = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // result checking at the edge that ends each strobe cycle
    always @(posedge i_clk) begin : result_check
        t_key_op_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual found %0d status %0d count %0d",
                         $time, o_found, o_status, o_key_count);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("found", want.found, o_found);
                compare_field("status", want.status, o_status);
                compare_field("key_count", want.count, o_key_count);
            end
        end
    end

    // extremes of the key, every mode, duplicate and absent cases at reset limit
    task automatic test_basic_ops();
        logic [KEY_W-1:0] absent_key;
        absent_key = $urandom_range(1, 32'h7FFF_FFFF);
        send_key_op(MODE_INSERT, 32'h0000_0000);       pause_sender(1'b1);
        send_key_op(MODE_INSERT, 32'hFFFF_FFFF);       pause_sender(1'b1);
        send_key_op(MODE_INSERT, 32'h0000_0000);       pause_sender(1'b1);
        send_key_op(MODE_SEARCH, 32'h0000_0000);       pause_sender(1'b1);
        send_key_op(MODE_ALIAS_SEARCH, 32'hFFFF_FFFF); pause_sender(1'b1);
        send_key_op(MODE_SEARCH, absent_key);          pause_sender(1'b1);
        send_key_op(MODE_DELETE, 32'hFFFF_FFFF);       pause_sender(1'b1);
        send_key_op(MODE_DELETE, 32'hFFFF_FFFF);       pause_sender(1'b1);
        send_key_op(MODE_SEARCH, 32'hFFFF_FFFF);       pause_sender(1'b1);
    endtask

    // keys sharing one home slot fill the probe window, then deleted slots
    task automatic test_probe_window();
        logic [KEY_W-1:0] cluster [MAX_PROBES + 1];
        int unsigned      home;
        home = $urandom_range(0, TABLE_SIZE - 1);
        foreach (cluster[i]) cluster[i] = key_with_home(home);
        write_fill_limit(11'd1024);
        // the last one finds no free slot in the window
        foreach (cluster[i]) begin
            send_key_op(MODE_INSERT, cluster[i]);
            pause_sender(1'b1);
        end
        send_key_op(MODE_SEARCH, cluster[5]);          pause_sender(1'b1);
        send_key_op(MODE_DELETE, cluster[3]);          pause_sender(1'b1);
        send_key_op(MODE_SEARCH, cluster[5]);          pause_sender(1'b1);
        send_key_op(MODE_SEARCH, cluster[MAX_PROBES]); pause_sender(1'b1);
        send_key_op(MODE_INSERT, cluster[MAX_PROBES]); pause_sender(1'b1);
        send_key_op(MODE_INSERT, cluster[MAX_PROBES]); pause_sender(1'b1);
    endtask

    // insert refused exactly at the fill limit, accepted one below it
    task automatic test_fill_limit();
        write_fill_limit(model_count);
        send_key_op(MODE_INSERT, $urandom);
        write_fill_limit(model_count + 1'b1);
        send_key_op(MODE_INSERT, $urandom);            pause_sender(1'b1);
        send_key_op(MODE_INSERT, $urandom);            pause_sender(1'b1);
    endtask

    // phases of mixed traffic over a pool of colliding keys, one limit per phase
    task automatic test_random_traffic();
        logic [KEY_W-1:0]  pool [POOL_SIZE];
        logic [CNT_W-1:0]  limit;
        logic [MODE_W-1:0] op;
        logic [KEY_W-1:0]  k;
        int unsigned       home;
        int                pick;
        bit                gaps_on;
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: limit = 11'd1024;
                1: limit = (model_count > 11'd1020) ? 11'd1024 : model_count + 11'd4;
                2: limit = 11'd0;
                3: limit = CNT_W'($urandom_range(0, 1024));
                4: limit = 11'd1;
                default: limit = FILL_LIMIT_RESET;
            endcase
            write_fill_limit(limit);
            // a third on one home, a third inside its window, a third anywhere
            home = $urandom_range(0, TABLE_SIZE - 1);
            for (int i = 0; i < POOL_SIZE; i++) begin
                if (i < 12) pool[i] = key_with_home(home);
                else if (i < 24) pool[i] = key_with_home(probe_at(home, $urandom_range(1, 5)));
                else pool[i] = $urandom;
            end
            gaps_on = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 25 == 0) gaps_on = ($urandom_range(0, 3) != 0);
                pick = $urandom_range(0, 99);
                if (pick < 45) op = MODE_INSERT;
                else if (pick < 70) op = MODE_SEARCH;
                else if (pick < 95) op = MODE_DELETE;
                else op = MODE_ALIAS_SEARCH;
                k = ($urandom_range(0, 4) == 0) ? $urandom : pool[$urandom_range(0, POOL_SIZE - 1)];
                send_key_op(op, k);
                pause_sender(gaps_on);
            end
        end
    endtask

    // main sequence
    initial begin
        for (int i = 0; i < TABLE_SIZE; i++) begin
            model_keys[i]  = '0;
            model_marks[i] = MARK_EMPTY;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_ops();
        test_probe_window();
        test_fill_limit();
        test_random_traffic();
        wait_for_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
